// ----- hw/rtl/spdpid_pkg.sv -----
// Shared definitions for the speed PID controller: field widths, register
// indexes, the command result struct and the 32-bit saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package spdpid_pkg;

    localparam int DATA_W        = 32;
    localparam int INT_OUT_W     = 21;
    localparam int DER_OUT_W     = 18;
    localparam int FRAC_BITS_DEF = 16;
    localparam int SAT_IN_W      = 66;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_TARGET = 2'd0,
        REG_GAIN_P = 2'd1,
        REG_GAIN_I = 2'd2,
        REG_GAIN_D = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] cmd;
        logic                     clear;
    } cmd_res_t;

    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic signed [DATA_W-1:0] r;
        if (v > SAT_IN_W'(DATA_MAX))
        begin
            r = DATA_MAX;
        end
        else if (v < SAT_IN_W'(DATA_MIN))
        begin
            r = DATA_MIN;
        end
        else
        begin
            r = DATA_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/spdpid_combine.sv -----
// Final stage arithmetic: rounds and saturates the three registered gain
// products, sums them and applies the command dead zone and the target dead-zone clear.
// Depends on spdpid_pkg.
`timescale 1ns / 1ps

module spdpid_combine #(
    parameter int FRAC_BITS = spdpid_pkg::FRAC_BITS_DEF,
    localparam int IW   = FRAC_BITS + 5,
    localparam int DW   = FRAC_BITS + 2,
    localparam int PP_W = 2 * spdpid_pkg::DATA_W,
    localparam int PI_W = spdpid_pkg::DATA_W + IW,
    localparam int PD_W = spdpid_pkg::DATA_W + DW
) (
    input  logic signed [PP_W-1:0] prod_p,
    input  logic signed [PI_W-1:0] prod_i,
    input  logic signed [PD_W-1:0] prod_d,
    input  logic                   tdz,
    output spdpid_pkg::cmd_res_t   res
);
    import spdpid_pkg::*;

    localparam int SUM_W = DATA_W + 2;
    localparam logic signed [DATA_W-1:0] OUT_DZ =
        DATA_W'(((64'sd5 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);

    logic signed [DATA_W-1:0] term_p;
    logic signed [DATA_W-1:0] term_i;
    logic signed [DATA_W-1:0] term_d;
    logic signed [DATA_W-1:0] cmd_sat;
    logic signed [SUM_W-1:0]  sum;
    logic                     cmd_tiny;

    // The products already carry the rounding offset, so a floor shift rounds.
    always_comb
    begin
        term_p   = sat_data(SAT_IN_W'(prod_p >>> FRAC_BITS));
        term_i   = sat_data(SAT_IN_W'(prod_i >>> FRAC_BITS));
        term_d   = sat_data(SAT_IN_W'(prod_d >>> FRAC_BITS));
        sum      = SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
        cmd_sat  = sat_data(SAT_IN_W'(sum));
        cmd_tiny = (cmd_sat < OUT_DZ) && (cmd_sat > -OUT_DZ);
        res.clear = tdz | cmd_tiny;
        res.cmd   = res.clear ? '0 : cmd_sat;
    end

endmodule

// ----- hw/rtl/speed_pid_deadzone_antiwindup.sv -----
// Top level of the speed PID controller with error and command dead zones
// and a clamped integral. Depends on spdpid_pkg and spdpid_combine.
`timescale 1ns / 1ps

// The controller takes one measured speed per item and returns one result per
// item: command, error after the dead zone, integral and derivative, all in
// signed fixed point with FRAC_BITS fraction bits. It sustains one item per
// clock while the output is not held back by cmd_ready; a result passes through
// four register stages (input, error, multiply, output). The integral feeds
// back from one item to the next, and the command dead zone of an item may
// clear it; the multiply stage therefore forms the integral and its gain
// product both with and without that clear, and the final stage picks one.
// Gains and target must be written through the configuration port only while
// no item is in flight; the block itself does not enforce this.
module speed_pid_deadzone_antiwindup #(
    parameter int FRAC_BITS = spdpid_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  spdpid_pkg::cfg_idx_t                          cfg_index,
    input  logic        [spdpid_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                          meas_valid,
    output logic                                          meas_ready,
    input  logic signed [spdpid_pkg::DATA_W-1:0]          measured_speed,
    output logic                                          cmd_valid,
    input  logic                                          cmd_ready,
    output logic signed [spdpid_pkg::DATA_W-1:0]          drive_command,
    output logic signed [spdpid_pkg::DATA_W-1:0]          error_value,
    output logic signed [spdpid_pkg::INT_OUT_W-1:0]       integral_value,
    output logic signed [spdpid_pkg::DER_OUT_W-1:0]       derivative_value
);
    import spdpid_pkg::*;

    localparam int IW   = FRAC_BITS + 5;
    localparam int EW   = FRAC_BITS + 6;
    localparam int DW   = FRAC_BITS + 2;
    localparam int DFW  = DATA_W + 1;
    localparam int PP_W = 2 * DATA_W;
    localparam int PI_W = DATA_W + IW;
    localparam int PD_W = DATA_W + DW;

    localparam logic signed [DATA_W-1:0] ERR_DZ =
        DATA_W'(((64'sd2 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
    localparam logic signed [DATA_W-1:0] TARGET_DZ =
        DATA_W'(((64'sd1 <<< FRAC_BITS) + 64'sd500) / 64'sd1000);
    localparam logic signed [DATA_W-1:0] E_LIM = DATA_W'(64'sd20 <<< FRAC_BITS);
    localparam logic signed [EW-1:0]     E_LIM_E = EW'(64'sd20 <<< FRAC_BITS);
    localparam logic signed [EW-1:0]     I_MAX_E = EW'(64'sd10 <<< FRAC_BITS);
    localparam logic signed [DFW-1:0]    D_MAX_F = DFW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PP_W-1:0]   HALF_P = PP_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [PI_W-1:0]   HALF_I = PI_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [PD_W-1:0]   HALF_D = PD_W'(64'sd1 <<< (FRAC_BITS - 1));

    // Configuration registers.
    logic signed [DATA_W-1:0] target_reg;
    logic signed [DATA_W-1:0] gain_p_reg;
    logic signed [DATA_W-1:0] gain_i_reg;
    logic signed [DATA_W-1:0] gain_d_reg;

    // Stage 1: captured measurement.
    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] meas_reg;

    // Stage 2: error after dead zone, previous error, clipped error.
    logic                     s2_valid_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] errb_reg;
    logic signed [EW-1:0]     erri_reg;
    logic                     tdz2_reg;

    // Stage 3: products and integral candidates.
    logic                     s3_valid_reg;
    logic signed [PP_W-1:0]   prod_p_reg;
    logic signed [PI_W-1:0]   prod_a_reg;
    logic signed [PI_W-1:0]   prod_b_reg;
    logic signed [PD_W-1:0]   prod_d_reg;
    logic signed [IW-1:0]     ia_reg;
    logic signed [IW-1:0]     ib_reg;
    logic signed [DW-1:0]     der3_reg;
    logic signed [DATA_W-1:0] err3_reg;
    logic                     tdz3_reg;
    logic                     spec_reg;

    // Controller state carried between items.
    logic signed [DATA_W-1:0] err_last_reg;
    logic signed [IW-1:0]     integ_reg;
    logic                     clr_last_reg;

    // Output register.
    logic                        out_valid_reg;
    logic signed [DATA_W-1:0]    cmd_out_reg;
    logic signed [DATA_W-1:0]    err_out_reg;
    logic signed [INT_OUT_W-1:0] int_out_reg;
    logic signed [DER_OUT_W-1:0] der_out_reg;

    logic out_free;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic s1_move;
    logic s2_move;
    logic s3_move;

    logic signed [DFW-1:0]    diff_in;
    logic signed [DATA_W-1:0] err_sat;
    logic signed [DATA_W-1:0] err_next;
    logic signed [EW-1:0]     erri_next;
    logic                     tdz_next;

    logic signed [DFW-1:0]    der_diff;
    logic signed [DW-1:0]     der_next;
    logic signed [IW-1:0]     base;
    logic signed [EW-1:0]     sum_a;
    logic signed [IW-1:0]     ia_next;
    logic signed [IW-1:0]     ib_next;
    logic signed [PP_W-1:0]   prod_p_next;
    logic signed [PI_W-1:0]   prod_a_next;
    logic signed [PI_W-1:0]   prod_b_next;
    logic signed [PD_W-1:0]   prod_d_next;

    logic                     use_b;
    logic signed [IW-1:0]     integ_pre;
    logic signed [IW-1:0]     integ_post;
    logic signed [PI_W-1:0]   prod_i_sel;
    logic signed [DW-1:0]     der_final;
    cmd_res_t                 res;

    // ---------------------------------------------------------------
    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET: target_reg <= cfg_data;
                REG_GAIN_P: gain_p_reg <= cfg_data;
                REG_GAIN_I: gain_i_reg <= cfg_data;
                REG_GAIN_D: gain_d_reg <= cfg_data;
                default:    target_reg <= target_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: each stage takes a new item when it is empty or moving on.
    assign out_free   = !out_valid_reg || cmd_ready;
    assign s3_ready   = !s3_valid_reg || out_free;
    assign s2_ready   = !s2_valid_reg || s3_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign s1_move    = s1_valid_reg && s2_ready;
    assign s2_move    = s2_valid_reg && s3_ready;
    assign s3_move    = s3_valid_reg && out_free;
    assign meas_ready = s1_ready;
    assign cmd_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= meas_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 to 2: error, dead zone and target dead zone.
    always_comb
    begin
        diff_in  = DFW'(target_reg) - DFW'(meas_reg);
        err_sat  = sat_data(SAT_IN_W'(diff_in));
        if ((err_sat < ERR_DZ) && (err_sat > -ERR_DZ))
        begin
            err_next = '0;
        end
        else
        begin
            err_next = err_sat;
        end
        // Clipping the error to twice the integral limit leaves the clamped
        // integral sum unchanged and keeps the adder narrow.
        if (err_next > E_LIM)
        begin
            erri_next = E_LIM_E;
        end
        else if (err_next < -E_LIM)
        begin
            erri_next = -E_LIM_E;
        end
        else
        begin
            erri_next = EW'(err_next);
        end
        tdz_next = (target_reg < TARGET_DZ) && (target_reg > -TARGET_DZ);
    end

    always_ff @(posedge clk)
    begin
        if (meas_valid && s1_ready)
        begin
            meas_reg <= measured_speed;
        end
        if (s1_move)
        begin
            err_reg  <= err_next;
            errb_reg <= err_last_reg;
            erri_reg <= erri_next;
            tdz2_reg <= tdz_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_last_reg <= '0;
        end
        else if (s1_move)
        begin
            err_last_reg <= err_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2 to 3: derivative, integral candidates and gain products.
    always_comb
    begin
        der_diff = DFW'(err_reg) - DFW'(errb_reg);
        if (der_diff > D_MAX_F)
        begin
            der_next = DW'(D_MAX_F);
        end
        else if (der_diff < -D_MAX_F)
        begin
            der_next = DW'(-D_MAX_F);
        end
        else
        begin
            der_next = DW'(der_diff);
        end

        // When the previous item is still in the final stage, its integral
        // before its own dead-zone clear is used, and the cleared case is
        // formed alongside as the second candidate.
        if (s3_valid_reg)
        begin
            base = integ_pre;
        end
        else
        begin
            base = integ_reg;
        end
        sum_a = EW'(base) + erri_reg;
        if (sum_a > I_MAX_E)
        begin
            ia_next = IW'(I_MAX_E);
        end
        else if (sum_a < -I_MAX_E)
        begin
            ia_next = IW'(-I_MAX_E);
        end
        else
        begin
            ia_next = IW'(sum_a);
        end
        if (erri_reg > I_MAX_E)
        begin
            ib_next = IW'(I_MAX_E);
        end
        else if (erri_reg < -I_MAX_E)
        begin
            ib_next = IW'(-I_MAX_E);
        end
        else
        begin
            ib_next = IW'(erri_reg);
        end

        prod_p_next = PP_W'(gain_p_reg) * PP_W'(err_reg) + HALF_P;
        prod_a_next = PI_W'(gain_i_reg) * PI_W'(ia_next) + HALF_I;
        prod_b_next = PI_W'(gain_i_reg) * PI_W'(ib_next) + HALF_I;
        prod_d_next = PD_W'(gain_d_reg) * PD_W'(der_next) + HALF_D;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            prod_p_reg <= prod_p_next;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_d_reg <= prod_d_next;
            ia_reg     <= ia_next;
            ib_reg     <= ib_next;
            der3_reg   <= der_next;
            err3_reg   <= err_reg;
            tdz3_reg   <= tdz2_reg;
            spec_reg   <= s3_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3 to output: pick the integral candidate and form the command.
    always_comb
    begin
        use_b      = spec_reg && clr_last_reg;
        integ_pre  = use_b ? ib_reg : ia_reg;
        prod_i_sel = use_b ? prod_b_reg : prod_a_reg;
        integ_post = res.clear ? '0 : integ_pre;
        der_final  = tdz3_reg ? '0 : der3_reg;
    end

    spdpid_combine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_combine (
        .prod_p (prod_p_reg),
        .prod_i (prod_i_sel),
        .prod_d (prod_d_reg),
        .tdz    (tdz3_reg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            clr_last_reg <= 1'b0;
        end
        else if (s3_move)
        begin
            integ_reg    <= integ_post;
            clr_last_reg <= res.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_move)
        begin
            cmd_out_reg <= res.cmd;
            err_out_reg <= err3_reg;
            int_out_reg <= INT_OUT_W'(integ_post);
            der_out_reg <= DER_OUT_W'(der_final);
        end
    end

    assign drive_command    = cmd_out_reg;
    assign error_value      = err_out_reg;
    assign integral_value   = int_out_reg;
    assign derivative_value = der_out_reg;

endmodule
